### rtl/core/pn_pkg.sv
// Shared types and constants for the path normalizer.
// Used by pn_path_mem, pn_parser, pn_emitter and path_normalizer.
package pn_pkg;

    localparam int MAX_PATH_BYTES = 64;
    localparam int NAME_LEN       = 32;
    localparam int MAX_DEPTH      = 32;

    // Fixed store geometry
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = 5;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NAME   = 2'd1,
        ST_DEPTH  = 2'd2,
        ST_OUTPUT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        DOT_NONE  = 2'd0,
        DOT_ONE   = 2'd1,
        DOT_TWO   = 2'd2,
        DOT_OTHER = 2'd3
    } t_dot;

    // Write port of the path store
    typedef struct packed {
        logic                wen;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

    // Request to emit one finished path
    typedef struct packed {
        logic                valid;
        t_status             status;
        logic [STORE_AW-1:0] len;
    } t_emit_req;

endpackage

### rtl/core/path_normalizer.sv
// Top level of the streaming path normalizer.
// Depends on pn_pkg, pn_path_mem, pn_parser and pn_emitter.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] in_char, tlast end_of_path
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] out_char, tuser[1:0] status,
//                                               tlast last_out
//
// An ordinary byte is taken in S_IN; a byte that closes a ".." component also passes
// through S_POP, which waits on the start-stack memory read.
// The final byte passes through S_FIN, then the path store is walked at one byte per
// cycle while m_axis_tready does not stall it; input is held off during the walk and
// until the parser, in S_WAIT, sees the emitter go idle.
// A status item is loaded with no store read. The output register lets the next path start
// while the last item still waits on m_axis_tready.
// Reset is synchronous, active low; the memories are not cleared.
module path_normalizer
    import pn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast
);

    t_store_wr           store_wr;
    t_emit_req           emit_req;
    logic                emit_busy;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;
    t_status             out_status;

    pn_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_char      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .o_store_wr  (store_wr),
        .o_req       (emit_req),
        .i_emit_busy (emit_busy)
    );

    pn_path_mem u_path_mem (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pn_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (emit_req),
        .o_busy    (emit_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_char    (m_axis_tdata),
        .o_status  (out_status),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_status;

endmodule

### rtl/core/pn_path_mem.sv
// Path store: single-port-write, single-port-read synchronous RAM.
// Depends on pn_pkg for geometry and the write port struct.
module pn_path_mem
    import pn_pkg::*;
(
    input  logic                i_clk,
    input  t_store_wr           i_wr,
    input  logic                i_rd_en,
    input  logic [STORE_AW-1:0] i_rd_addr,
    output logic [7:0]          o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    // Write one byte
    always_ff @(posedge i_clk) begin
        if (i_wr.wen) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/pn_parser.sv
// Input side: tracks names, dot patterns and depth, writes the path store
// and owns the component start stack. Depends on pn_pkg.
module pn_parser
    import pn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic [7:0] i_char,
    input  logic      i_last,
    output logic      o_ready,
    output t_store_wr o_store_wr,
    output t_emit_req o_req,
    input  logic      i_emit_busy
);

    typedef enum logic [3:0] {
        S_IN   = 4'b0001,
        S_POP  = 4'b0010,
        S_FIN  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_depth, n_depth;
    logic [6:0] r_wp, n_wp;
    logic [5:0] r_nl, n_nl;
    logic [6:0] r_icnt, n_icnt;
    t_dot       r_dot, n_dot;
    t_status    r_err, n_err;
    logic       r_rel, n_rel;
    logic       r_lastp, n_lastp;

    // Start stack memory
    logic [5:0]          r_stack [STACK_DEPTH];
    logic [5:0]          r_stack_rd;
    logic                stk_wen;
    logic [STACK_AW-1:0] stk_waddr;
    logic                stk_ren;
    logic [STACK_AW-1:0] stk_raddr;

    logic       accept;
    logic       take;
    logic       is_slash;
    logic       fin_go;
    logic [5:0] fin_nl;
    t_dot       fin_dot;
    t_dot       tk_dot;
    logic [5:0] tk_nl;
    t_status    tk_err;
    logic [6:0] idx_char;
    logic [6:0] idx_slash;
    logic [6:0] out_len;
    t_status    fin_status;

    assign o_ready  = (r_state == S_IN);
    assign accept   = i_valid && o_ready;
    assign is_slash = (i_char == CHAR_SLASH);
    assign take     = (r_err == ST_OK) && (r_icnt < 7'(MAX_PATH_BYTES - 1));
    assign idx_char = r_wp + 7'(r_nl);

    // Finished path length and status
    always_comb begin
        out_len    = (r_depth == 6'd0) ? 7'd1 : (r_wp - 7'd1);
        fin_status = r_err;
        if (r_rel && (r_icnt > 7'(MAX_PATH_BYTES - 3))) begin
            fin_status = ST_OUTPUT;
        end
        if ((fin_status == ST_OK) && (out_len > 7'(MAX_PATH_BYTES - 2))) begin
            fin_status = ST_OUTPUT;
        end
    end

    // Take one byte, then close the name on a separator or at end of path; pop, hand off, wait
    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_wp       = r_wp;
        n_nl       = r_nl;
        n_icnt     = r_icnt;
        n_dot      = r_dot;
        n_err      = r_err;
        n_rel      = r_rel;
        n_lastp    = r_lastp;
        o_store_wr = '{wen: 1'b0, addr: '0, data: i_char};
        stk_wen    = 1'b0;
        stk_waddr  = r_depth[STACK_AW-1:0];
        stk_ren    = 1'b0;
        stk_raddr  = STACK_AW'(r_depth - 6'd1);
        o_req      = '{valid: 1'b0, status: fin_status, len: out_len[STORE_AW-1:0]};
        tk_dot     = r_dot;
        tk_nl      = r_nl;
        tk_err     = r_err;
        fin_go     = 1'b0;
        fin_nl     = r_nl;
        fin_dot    = r_dot;
        idx_slash  = r_wp + 7'(r_nl);

        unique case (r_state)
            S_IN: begin
                if (accept) begin
                    // byte handling
                    if (take) begin
                        if ((r_icnt == 7'd0) && !is_slash) begin
                            n_rel = 1'b1;
                        end
                        n_icnt = r_icnt + 7'd1;
                        if (!is_slash) begin
                            if ((7'(r_nl) + 7'd1) >= 7'(NAME_LEN)) begin
                                tk_err = ST_NAME;
                            end else begin
                                if (r_nl == 6'd0) begin
                                    tk_dot = (i_char == CHAR_DOT) ? DOT_ONE : DOT_OTHER;
                                end else if ((r_nl == 6'd1) && (r_dot == DOT_ONE)
                                             && (i_char == CHAR_DOT)) begin
                                    tk_dot = DOT_TWO;
                                end else begin
                                    tk_dot = DOT_OTHER;
                                end
                                tk_nl = r_nl + 6'd1;
                                if (idx_char < 7'(MAX_PATH_BYTES)) begin
                                    o_store_wr.wen  = 1'b1;
                                    o_store_wr.addr = idx_char[STORE_AW-1:0];
                                end
                            end
                        end
                    end
                    n_err = tk_err;
                    n_dot = tk_dot;
                    n_nl  = tk_nl;
                    fin_go  = (take && is_slash) || (i_last && (tk_err == ST_OK));
                    fin_nl  = tk_nl;
                    fin_dot = tk_dot;
                    idx_slash = r_wp + 7'(fin_nl);

                    // close the name
                    if (fin_go) begin
                        n_nl  = 6'd0;
                        n_dot = DOT_NONE;
                        if (fin_nl != 6'd0) begin
                            if (fin_dot == DOT_TWO) begin
                                if (r_depth != 6'd0) begin
                                    n_depth = r_depth - 6'd1;
                                    stk_ren = 1'b1;
                                end
                            end else if (fin_dot != DOT_ONE) begin
                                if (r_depth >= 6'(MAX_DEPTH)) begin
                                    n_err = ST_DEPTH;
                                end else begin
                                    stk_wen = 1'b1;
                                    n_wp    = r_wp + 7'(fin_nl) + 7'd1;
                                    n_depth = r_depth + 6'd1;
                                    // trailing separator at end of path is never shown
                                    if (is_slash && take
                                        && (idx_slash < 7'(MAX_PATH_BYTES))) begin
                                        o_store_wr.wen  = 1'b1;
                                        o_store_wr.addr = idx_slash[STORE_AW-1:0];
                                        o_store_wr.data = CHAR_SLASH;
                                    end
                                end
                            end
                        end
                    end

                    n_lastp = i_last;
                    if (stk_ren) begin
                        n_state = S_POP;
                    end else if (i_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_POP: begin
                // restore write position from the stack
                n_wp    = {1'b0, r_stack_rd};
                n_state = r_lastp ? S_FIN : S_IN;
            end
            S_FIN: begin
                // hand off and clear per-path state
                o_req.valid = 1'b1;
                n_depth = 6'd0;
                n_wp    = 7'd1;
                n_nl    = 6'd0;
                n_icnt  = 7'd0;
                n_dot   = DOT_NONE;
                n_err   = ST_OK;
                n_rel   = 1'b0;
                n_lastp = 1'b0;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_emit_busy) begin
                    n_state = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_depth <= 6'd0;
            r_wp    <= 7'd1;
            r_nl    <= 6'd0;
            r_icnt  <= 7'd0;
            r_dot   <= DOT_NONE;
            r_err   <= ST_OK;
            r_rel   <= 1'b0;
            r_lastp <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_wp    <= n_wp;
            r_nl    <= n_nl;
            r_icnt  <= n_icnt;
            r_dot   <= n_dot;
            r_err   <= n_err;
            r_rel   <= n_rel;
            r_lastp <= n_lastp;
        end
    end

    // Start stack: push writes, pop reads into a register used in S_POP
    always_ff @(posedge i_clk) begin
        if (stk_wen) begin
            r_stack[stk_waddr] <= r_wp[5:0];
        end
        if (stk_ren) begin
            r_stack_rd <= r_stack[stk_raddr];
        end
    end

    // Depth never exceeds the limit
    a_depth_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= 6'(MAX_DEPTH))
        else $error("depth above limit");

    // A pop always leaves room below the limit
    a_pop_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_depth < 6'(MAX_DEPTH)))
        else $error("pop with bad depth");

    // Push and pop never coincide
    a_stack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stk_wen && stk_ren))
        else $error("stack push and pop together");

endmodule

### rtl/core/pn_emitter.sv
// Output side: walks the path store one byte a cycle, unless the output stalls, into an output register,
// or sends a single status item. Depends on pn_pkg.
module pn_emitter
    import pn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_emit_req           i_req,
    output logic                o_busy,
    output logic                o_rd_en,
    output logic [STORE_AW-1:0] o_rd_addr,
    input  logic [7:0]          i_rd_data,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [7:0]          o_char,
    output t_status             o_status,
    output logic                o_last
);

    typedef enum logic [1:0] {
        E_IDLE = 2'b01,
        E_RUN  = 2'b10
    } t_estate;

    t_estate             r_state, n_state;
    t_status             r_status, n_status;
    logic [STORE_AW-1:0] r_len, n_len;
    logic [STORE_AW-1:0] r_k, n_k;
    logic                r_rdv, n_rdv;
    logic                r_ovld, n_ovld;
    logic [7:0]          r_char, n_char;
    t_status             r_ostat, n_ostat;
    logic                r_olast, n_olast;
    logic                can_load;
    logic                load;
    logic                is_last;

    assign can_load = !r_ovld || i_tready;
    assign is_last  = (r_k == (r_len - STORE_AW'(1)));
    assign load     = (r_state == E_RUN) && can_load
                      && ((r_status != ST_OK) || r_rdv);

    // Walk the store and fill the output register
    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_len     = r_len;
        n_k       = r_k;
        n_rdv     = r_rdv;
        n_ovld    = r_ovld && !i_tready;
        n_char    = r_char;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        o_rd_en   = 1'b0;
        o_rd_addr = r_k;

        unique case (r_state)
            E_IDLE: begin
                if (i_req.valid) begin
                    n_state  = E_RUN;
                    n_status = i_req.status;
                    n_len    = i_req.len;
                    n_k      = '0;
                    n_rdv    = 1'b0;
                end
            end
            E_RUN: begin
                if (r_status != ST_OK) begin
                    // single status item
                    if (load) begin
                        n_ovld  = 1'b1;
                        n_char  = CHAR_NUL;
                        n_ostat = r_status;
                        n_olast = 1'b1;
                        n_state = E_IDLE;
                    end
                end else if (load) begin
                    n_ovld  = 1'b1;
                    n_char  = (r_k == '0) ? CHAR_SLASH : i_rd_data;
                    n_ostat = ST_OK;
                    n_olast = is_last;
                    if (is_last) begin
                        n_state = E_IDLE;
                        n_rdv   = 1'b0;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_k + STORE_AW'(1);
                        n_k       = r_k + STORE_AW'(1);
                    end
                end else if (!r_rdv) begin
                    o_rd_en = 1'b1;
                    n_rdv   = 1'b1;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_rdv   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= n_rdv;
            r_ovld  <= n_ovld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_len    <= n_len;
        r_k      <= n_k;
        r_char   <= n_char;
        r_ostat  <= n_ostat;
        r_olast  <= n_olast;
    end

    assign o_busy   = (r_state != E_IDLE);
    assign o_tvalid = r_ovld;
    assign o_char   = r_char;
    assign o_status = r_ostat;
    assign o_last   = r_olast;

    // Final item ends the walk
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && ((r_status != ST_OK) || is_last)) |=> !o_busy)
        else $error("walk continues after final item");

    // No store reads while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_IDLE) |-> !o_rd_en)
        else $error("store read while idle");

    // Status items are single and final
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_ostat != ST_OK)) |-> (r_olast && (r_char == CHAR_NUL)))
        else $error("malformed status item");

endmodule

### tb/canon_path_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the path normalizer: predicts the canonical path from the input items
// and compares every output item. Depends on pn_pkg for types and constants.
module canon_path_checker
    import pn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,      // [7:0] in_char
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,     // [7:0] out_char
    input  logic [1:0] i_out_user,     // [1:0] status
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_char_count,
    output int         o_status_count
);

    typedef struct packed {
        logic [7:0] ch;
        t_status    status;
        logic       is_last;
    } t_canon_item;

    t_canon_item canon_bytes_due[$];
    t_canon_item want;

    // Predictor state
    logic [7:0] name_store [STORE_DEPTH];
    logic [7:0] comp_start [STACK_DEPTH];
    int         kept_depth;
    int         next_pos;
    int         cur_len;
    int         byte_count;
    t_dot       cur_dot;
    t_status    first_err;
    bit         relative_path;

    int         fail_total;
    int         char_total;
    int         status_total;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) name_store[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++) comp_start[i] = '0;
        fail_total   = 0;
        char_total   = 0;
        status_total = 0;
    end

    function void clear_canon_path();
        name_store[0] = CHAR_SLASH;
        kept_depth    = 0;
        next_pos      = 1;
        cur_len       = 0;
        byte_count    = 0;
        cur_dot       = DOT_NONE;
        first_err     = ST_OK;
        relative_path = 1'b0;
    endfunction

    function void put_store(input int idx, input logic [7:0] c);
        if (idx < MAX_PATH_BYTES && idx < STORE_DEPTH) name_store[idx] = c;
    endfunction

    // Close the name in progress: drop ".", pop on "..", push anything else
    function void close_component();
        if (cur_len != 0) begin
            if (cur_dot == DOT_TWO) begin
                if (kept_depth > 0) begin
                    kept_depth = kept_depth - 1;
                    next_pos   = comp_start[kept_depth & 31];
                end
            end else if (cur_dot != DOT_ONE) begin
                if (kept_depth >= MAX_DEPTH || kept_depth >= STACK_DEPTH) begin
                    first_err = ST_DEPTH;
                end else begin
                    comp_start[kept_depth] = 8'(next_pos);
                    put_store(next_pos + cur_len, CHAR_SLASH);
                    next_pos   = next_pos + cur_len + 1;
                    kept_depth = kept_depth + 1;
                end
            end
            cur_len = 0;
            cur_dot = DOT_NONE;
        end
    endfunction

    function void take_path_byte(input logic [7:0] c);
        if (byte_count == 0 && c != CHAR_SLASH) relative_path = 1'b1;
        byte_count = byte_count + 1;
        if (c == CHAR_SLASH) begin
            close_component();
        end else if (cur_len + 1 >= NAME_LEN) begin
            first_err = ST_NAME;
        end else begin
            if (cur_len == 0) cur_dot = (c == CHAR_DOT) ? DOT_ONE : DOT_OTHER;
            else if (cur_len == 1 && cur_dot == DOT_ONE && c == CHAR_DOT) cur_dot = DOT_TWO;
            else cur_dot = DOT_OTHER;
            put_store(next_pos + cur_len, c);
            cur_len = cur_len + 1;
        end
    endfunction

    // Advance the predictor by one input item; queue the output items it causes
    function void canonicalize_byte(input logic [7:0] c, input logic is_last);
        int          out_len;
        t_status     res;
        t_canon_item item;
        if (first_err == ST_OK && byte_count < MAX_PATH_BYTES - 1) take_path_byte(c);
        if (is_last) begin
            if (first_err == ST_OK) close_component();
            res = first_err;
            if (relative_path && byte_count > MAX_PATH_BYTES - 3) res = ST_OUTPUT;
            out_len = (kept_depth == 0) ? 1 : next_pos - 1;
            if (res == ST_OK && out_len > MAX_PATH_BYTES - 2) res = ST_OUTPUT;
            if (res != ST_OK) begin
                item.ch      = CHAR_NUL;
                item.status  = res;
                item.is_last = 1'b1;
                canon_bytes_due.push_back(item);
            end else begin
                for (int k = 0; k < out_len && k < STORE_DEPTH; k++) begin
                    item.ch      = name_store[k];
                    item.status  = ST_OK;
                    item.is_last = (k + 1 == out_len);
                    canon_bytes_due.push_back(item);
                end
            end
            clear_canon_path();
        end
    endfunction

    // Check the output first so that an item predicted at this edge cannot match it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_canon_path();
            canon_bytes_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (canon_bytes_due.size() == 0) begin
                    fail_total = fail_total + 1;
                    if (fail_total <= 10)
                        $display("checker: unexpected output item char %h status %0d last %0b",
                                 i_out_data, i_out_user, i_out_last);
                end else begin
                    want = canon_bytes_due.pop_front();
                    if (want.status == ST_OK) char_total = char_total + 1;
                    else status_total = status_total + 1;
                    if (i_out_data !== want.ch || i_out_user !== want.status ||
                        i_out_last !== want.is_last) begin
                        fail_total = fail_total + 1;
                        if (fail_total <= 10)
                            $display("checker: mismatch at %0t: exp/act char %h/%h st %0d/%0d lst %0b/%0b",
                                     $realtime, want.ch, i_out_data, want.status, i_out_user,
                                     want.is_last, i_out_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) canonicalize_byte(i_in_data, i_in_last);
        end
        o_fail_count   <= fail_total;
        o_pending      <= canon_bytes_due.size();
        o_char_count   <= char_total;
        o_status_count <= status_total;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the path normalizer testbench: clock, reset, path stimulus and verdict.
// Depends on pn_pkg, path_normalizer and canon_path_checker.
module tb;
    import pn_pkg::*;

    localparam int ITEM_TARGET = 380;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 80;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;     // [7:0] in_char
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic [1:0] m_axis_tuser;           // [1:0] status
    logic       m_axis_tlast;

    int         fail_count;
    int         pending;
    int         char_count;
    int         status_count;

    int         tx_idle_pct = 32;
    int         rx_idle_pct = 32;
    bit         rx_hold_req = 1'b0;
    int         items_sent  = 0;
    int         paths_sent  = 0;
    int         quiet_cycles = 0;
    logic [7:0] byte_q[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    path_normalizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    canon_path_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_user     (m_axis_tuser),
        .i_out_last     (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_char_count   (char_count),
        .o_status_count (status_count)
    );

    // Stall the output at random; hold it off for a long stretch on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item after a random gap; return at the edge that accepts it
    task automatic send_byte(input logic [7:0] c, input logic is_last);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_path();
        for (int i = 0; i < byte_q.size(); i++) send_byte(byte_q[i], i == byte_q.size() - 1);
        items_sent = items_sent + byte_q.size();
        paths_sent = paths_sent + 1;
    endtask

    task automatic send_text(input string s);
        byte_q.delete();
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
        send_path();
    endtask

    // Drop valid and wait until every predicted item has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Name byte: any nonzero value but the separator, often a dot
    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(4) == 0) begin
            c = CHAR_DOT;
        end else begin
            do c = 8'($urandom_range(1, 255)); while (c == CHAR_SLASH);
        end
        return c;
    endfunction

    task automatic add_name(input int n);
        repeat (n) byte_q.push_back(name_char());
    endtask

    // Build one random path: mostly well-formed, some long, deep or noisy
    task automatic build_path();
        int kind;
        int ncomp;
        int pick;
        int target;
        byte_q.delete();
        kind = $urandom_range(99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 10)) begin
                pick = $urandom_range(2);
                if (pick == 0) byte_q.push_back(CHAR_SLASH);
                else if (pick == 1) byte_q.push_back(CHAR_DOT);
                else byte_q.push_back(name_char());
            end
        end else begin
            if ($urandom_range(3) != 0) byte_q.push_back(CHAR_SLASH);
            if (kind < 55) begin
                ncomp = $urandom_range(1, 6);
                for (int i = 0; i < ncomp; i++) begin
                    pick = $urandom_range(9);
                    if (pick < 2) begin
                        byte_q.push_back(CHAR_DOT);
                    end else if (pick < 4) begin
                        byte_q.push_back(CHAR_DOT);
                        byte_q.push_back(CHAR_DOT);
                    end else begin
                        add_name($urandom_range(1, 6));
                    end
                    if (i < ncomp - 1 || $urandom_range(1) == 0) byte_q.push_back(CHAR_SLASH);
                    if ($urandom_range(7) == 0) byte_q.push_back(CHAR_SLASH);
                end
            end else if (kind < 67) begin
                // names around the length limit
                add_name($urandom_range(1, 4));
                byte_q.push_back(CHAR_SLASH);
                add_name($urandom_range(29, 34));
                if ($urandom_range(1) == 0) begin
                    byte_q.push_back(CHAR_SLASH);
                    add_name(2);
                end
            end else if (kind < 80) begin
                // paths around the length limit, truncated past it
                target = $urandom_range(58, 72);
                while (byte_q.size() < target) begin
                    add_name($urandom_range(1, 8));
                    byte_q.push_back(CHAR_SLASH);
                end
                if ($urandom_range(1) == 0) void'(byte_q.pop_back());
            end else begin
                // many pushes and pops
                repeat ($urandom_range(8, 24)) begin
                    if ($urandom_range(2) == 0) begin
                        byte_q.push_back(CHAR_DOT);
                        byte_q.push_back(CHAR_DOT);
                    end else begin
                        add_name($urandom_range(1, 3));
                    end
                    byte_q.push_back(CHAR_SLASH);
                end
            end
        end
    endtask

    initial begin
        int path_idx;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: root, pop at root, dot drop, pop and trailing slash, odd name bytes
        send_text("/");
        send_text("/..");
        send_text("a/./b");
        send_text("/x/../y/");
        send_text("...");
        byte_q.delete();
        byte_q.push_back(CHAR_SLASH);
        byte_q.push_back(8'h01);
        byte_q.push_back(CHAR_SLASH);
        byte_q.push_back(CHAR_NUL);
        byte_q.push_back(8'hFF);
        send_path();

        // Random paths
        path_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (path_idx == 4) rx_hold_req = 1'b1;
            if (path_idx == 10) wait_drained();
            if (path_idx == 14) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (path_idx == 20) begin
                tx_idle_pct = 32;
                rx_idle_pct = 32;
            end
            build_path();
            send_path();
            path_idx = path_idx + 1;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d paths in %0d input items; %0d path bytes and %0d status items out",
                 paths_sent, items_sent, char_count, status_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/pn_pkg.sv
rtl/core/pn_path_mem.sv
rtl/core/pn_parser.sv
rtl/core/pn_emitter.sv
rtl/core/path_normalizer.sv
tb/canon_path_checker.sv
tb/tb.sv
